// File: rtl/ctac_pkg.sv
`timescale 1ns / 1ps

package ctac_pkg;

    // request actions
    localparam logic [1:0] ACT_SET_ALARM     = 2'd0;
    localparam logic [1:0] ACT_ELAPSED_ALARM = 2'd1;
    localparam logic [1:0] ACT_ELAPSED_SAVED = 2'd2;
    localparam logic [1:0] ACT_READ_TICK     = 2'd3;

    // configuration register indexes (byte address 4*index)
    localparam logic REG_WAKE_UP_TIME  = 1'b0;
    localparam logic REG_TIMEOUT_FLOOR = 1'b1;

    localparam logic [7:0] WAKE_UP_TIME_RST  = 8'd2;
    localparam logic [5:0] TIMEOUT_FLOOR_RST = 6'd2;

    localparam logic [31:0] TICK_WRAP     = 32'd1540898437;
    localparam int          LONG_LIMIT    = 2160000;
    localparam logic [31:0] SHORT_LIMIT   = 32'd50;
    localparam logic [6:0]  LONG_DAY_STEP = 7'd25;

    // smallest adjusted timeout whose 2.048 s scaling exceeds LONG_LIMIT
    localparam logic [31:0] TADJ_LONG_MIN = 32'((((LONG_LIMIT + 1) * 125) + 255) / 256);

    // exact reciprocals: floor(x * R >> k) == x / d for x < 2^n, k = n + ceil(log2 d)
    localparam int          SHIFT_125 = 36;
    localparam logic [29:0] RECIP_125 = 30'(((64'd1 << SHIFT_125) + 64'd124) / 64'd125);
    localparam int          SHIFT_60  = 29;
    localparam logic [23:0] RECIP_60  = 24'(((64'd1 << SHIFT_60) + 64'd59) / 64'd60);
    localparam int          SHIFT_24  = 15;
    localparam logic [10:0] RECIP_24  = 11'(((64'd1 << SHIFT_24) + 64'd23) / 64'd24);

    typedef struct packed {
        logic [1:0]  action;
        logic [6:0]  year;
        logic [3:0]  month;
        logic [4:0]  date_of_month;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [31:0] timeout;
        logic        stop_mode;
        logic [30:0] saved_tick;
    } request_t;

    typedef struct packed {
        logic        alarm_armed;
        logic [5:0]  alarm_day;
        logic [4:0]  alarm_hours;
        logic [5:0]  alarm_minutes;
        logic [5:0]  alarm_seconds;
        logic [31:0] tick_value;
    } result_t;

    // one step strobe per datapath stage
    typedef struct packed {
        logic load;
        logic hours;
        logic mins;
        logic secs;
        logic tick;
        logic divb;
        logic remb;
        logic div24;
        logic finish;
    } cmd_t;

    function automatic logic [8:0] month_start(input logic [3:0] mi);
        logic [8:0] r;
        unique case (mi)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd59;
            4'd3:    r = 9'd90;
            4'd4:    r = 9'd120;
            4'd5:    r = 9'd151;
            4'd6:    r = 9'd181;
            4'd7:    r = 9'd212;
            4'd8:    r = 9'd243;
            4'd9:    r = 9'd273;
            4'd10:   r = 9'd304;
            default: r = 9'd334;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] month_len(input logic [3:0] mi);
        logic [5:0] r;
        unique case (mi)
            4'd1:                    r = 6'd28;
            4'd3, 4'd5, 4'd8, 4'd10: r = 6'd30;
            default:                 r = 6'd31;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/ctac_regs.sv
`timescale 1ns / 1ps

module ctac_regs
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  wake_up_time,
    output logic [5:0]  timeout_floor
);

    logic [7:0] wake_up_time_reg, wake_up_time_next;
    logic [5:0] timeout_floor_reg, timeout_floor_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb
    begin
        wake_up_time_next  = wake_up_time_reg;
        timeout_floor_next = timeout_floor_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                ctac_pkg::REG_WAKE_UP_TIME:  wake_up_time_next  = pwdata[7:0];
                ctac_pkg::REG_TIMEOUT_FLOOR: timeout_floor_next = pwdata[5:0];
                default:                     wake_up_time_next  = wake_up_time_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wake_up_time_reg  <= ctac_pkg::WAKE_UP_TIME_RST;
            timeout_floor_reg <= ctac_pkg::TIMEOUT_FLOOR_RST;
        end
        else
        begin
            wake_up_time_reg  <= wake_up_time_next;
            timeout_floor_reg <= timeout_floor_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            ctac_pkg::REG_WAKE_UP_TIME:  prdata = 32'(wake_up_time_reg);
            ctac_pkg::REG_TIMEOUT_FLOOR: prdata = 32'(timeout_floor_reg);
            default:                     prdata = 32'd0;
        endcase
    end

    assign wake_up_time  = wake_up_time_reg;
    assign timeout_floor = timeout_floor_reg;

endmodule

// File: rtl/ctac_dp.sv
`timescale 1ns / 1ps

module ctac_dp
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctac_pkg::cmd_t     cmd,
    input  ctac_pkg::request_t request,
    input  logic [7:0]         wake_up_time,
    input  logic [5:0]         timeout_floor,
    output ctac_pkg::result_t  result
);

    ctac_pkg::request_t req_reg, req_next;
    ctac_pkg::result_t  out_reg, out_next;
    logic [3:0]  mi_reg, mi_next;
    logic [15:0] days_reg, days_next;
    logic [31:0] tadj_reg, tadj_next;
    logic [31:0] acc_reg, acc_next;
    logic [22:0] scaled_reg, scaled_next;
    logic        long_reg, long_next;
    logic [22:0] div_reg, div_next;
    logic [17:0] quo_reg, quo_next;
    logic [31:0] tick_reg, tick_next;
    logic [5:0]  as_reg, as_next;
    logic [5:0]  am_reg, am_next;
    logic [9:0]  z_reg, z_next;
    logic [5:0]  qd_reg, qd_next;
    logic [30:0] ctx_reg, ctx_next;

    // load-time calendar terms
    logic [3:0]  mi;
    logic [5:0]  leaps;
    logic        extra;
    logic [15:0] days_raw;
    logic [31:0] t_clamped;

    logic [58:0] prod125;
    logic [46:0] prod60;
    logic [39:0] tick_prod;
    logic [25:0] prod24;

    // finish-time terms
    logic        armed;
    logic [6:0]  ad;
    logic [6:0]  dim;
    logic [6:0]  ad_wrapped;
    logic [4:0]  ah;
    logic [30:0] ref_tick;
    logic [31:0] elapsed;

    always_comb
    begin
        if (request.month == 4'd0)
            mi = 4'd0;
        else if (request.month > 4'd12)
            mi = 4'd11;
        else
            mi = request.month - 4'd1;

        leaps = (request.year == 7'd0) ? 6'd0
                                       : 6'((request.year - 7'd1) >> 2) + 6'd1;
        extra = (request.year[1:0] == 2'd0) && (mi > 4'd1);
        days_raw = 16'(16'(request.year) * 16'd365) + 16'(leaps)
                 + 16'(ctac_pkg::month_start(mi)) + 16'(request.date_of_month)
                 + 16'(extra);

        if (request.timeout < ctac_pkg::SHORT_LIMIT
            && request.timeout < 32'(timeout_floor))
            t_clamped = 32'(timeout_floor);
        else
            t_clamped = request.timeout;
    end

    assign prod125   = 59'({tadj_reg[20:0], 8'd0}) * 59'(ctac_pkg::RECIP_125);
    assign prod60    = 47'(div_reg) * 47'(ctac_pkg::RECIP_60);
    assign tick_prod = 40'(acc_reg) * 40'd125 + 40'd128;
    assign prod24    = 26'(z_reg) * 26'(ctac_pkg::RECIP_24);

    always_comb
    begin
        armed = (req_reg.action == ctac_pkg::ACT_SET_ALARM) && (req_reg.timeout != 32'd0);

        dim = 7'(ctac_pkg::month_len(mi_reg));
        if (req_reg.year[1:0] == 2'd0 && mi_reg == 4'd1)
            dim = 7'd29;

        ah = 5'(z_reg - 10'(10'(qd_reg) * 10'd24));
        if (long_reg)
            ad = 7'(req_reg.date_of_month) + ctac_pkg::LONG_DAY_STEP;
        else
            ad = 7'(qd_reg) + 7'(req_reg.date_of_month);

        // day is below three month lengths, so at most two subtractions
        if (ad <= dim)
            ad_wrapped = ad;
        else if (ad >= 7'(dim << 1))
            ad_wrapped = ad - 7'(dim << 1);
        else
            ad_wrapped = ad - dim;

        ref_tick = (req_reg.action == ctac_pkg::ACT_ELAPSED_ALARM) ? ctx_reg
                                                                    : req_reg.saved_tick;
        if (tick_reg >= 32'(ref_tick))
            elapsed = tick_reg - 32'(ref_tick);
        else
            elapsed = tick_reg + ctac_pkg::TICK_WRAP - 32'(ref_tick);
    end

    always_comb
    begin
        req_next    = req_reg;
        out_next    = out_reg;
        mi_next     = mi_reg;
        days_next   = days_reg;
        tadj_next   = tadj_reg;
        acc_next    = acc_reg;
        scaled_next = scaled_reg;
        long_next   = long_reg;
        div_next    = div_reg;
        quo_next    = quo_reg;
        tick_next   = tick_reg;
        as_next     = as_reg;
        am_next     = am_reg;
        z_next      = z_reg;
        qd_next     = qd_reg;
        ctx_next    = ctx_reg;

        if (cmd.load)
        begin
            req_next  = request;
            mi_next   = mi;
            days_next = (days_raw == 16'd0) ? 16'd0 : days_raw - 16'd1;
            tadj_next = request.stop_mode ? t_clamped - 32'(wake_up_time) : t_clamped;
        end
        if (cmd.hours)
        begin
            acc_next    = 32'(days_reg) * 32'd24 + 32'(req_reg.hours);
            scaled_next = 23'(prod125 >> ctac_pkg::SHIFT_125);
            long_next   = tadj_reg >= ctac_pkg::TADJ_LONG_MIN;
        end
        if (cmd.mins)
        begin
            acc_next = acc_reg * 32'd60 + 32'(req_reg.minutes);
            div_next = scaled_reg + 23'(req_reg.seconds);
        end
        if (cmd.secs)
        begin
            acc_next = acc_reg * 32'd60 + 32'(req_reg.seconds);
            quo_next = 18'(prod60 >> ctac_pkg::SHIFT_60);
        end
        if (cmd.tick)
        begin
            tick_next = 32'(tick_prod >> 8);
            as_next   = 6'(div_reg - 23'(23'(quo_reg) * 23'd60));
            div_next  = 23'(quo_reg) + 23'(req_reg.minutes);
        end
        if (cmd.divb)
            quo_next = 18'(prod60 >> ctac_pkg::SHIFT_60);
        if (cmd.remb)
        begin
            am_next = 6'(div_reg - 23'(23'(quo_reg) * 23'd60));
            z_next  = 10'(quo_reg + 18'(req_reg.hours));
        end
        if (cmd.div24)
            qd_next = 6'(prod24 >> ctac_pkg::SHIFT_24);
        if (cmd.finish)
        begin
            out_next.alarm_armed   = armed;
            out_next.alarm_day     = armed ? 6'(ad_wrapped) : 6'd0;
            out_next.alarm_hours   = !armed ? 5'd0 : (long_reg ? req_reg.hours : ah);
            out_next.alarm_minutes = !armed ? 6'd0 : (long_reg ? req_reg.minutes : am_reg);
            out_next.alarm_seconds = !armed ? 6'd0 : (long_reg ? req_reg.seconds : as_reg);
            unique case (req_reg.action)
                ctac_pkg::ACT_ELAPSED_ALARM,
                ctac_pkg::ACT_ELAPSED_SAVED: out_next.tick_value = elapsed;
                ctac_pkg::ACT_SET_ALARM,
                ctac_pkg::ACT_READ_TICK:     out_next.tick_value = tick_reg;
                default:                     out_next.tick_value = tick_reg;
            endcase
            if (armed)
                ctx_next = tick_reg[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        out_reg    <= out_next;
        mi_reg     <= mi_next;
        days_reg   <= days_next;
        tadj_reg   <= tadj_next;
        acc_reg    <= acc_next;
        scaled_reg <= scaled_next;
        long_reg   <= long_next;
        div_reg    <= div_next;
        quo_reg    <= quo_next;
        tick_reg   <= tick_next;
        as_reg     <= as_next;
        am_reg     <= am_next;
        z_reg      <= z_next;
        qd_reg     <= qd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctx_reg <= 31'd0;
        else
            ctx_reg <= ctx_next;
    end

    assign result = out_reg;

endmodule

// File: rtl/ctac_ctrl.sv
`timescale 1ns / 1ps

module ctac_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           request_valid,
    output logic           request_stall,
    output logic           result_valid,
    input  logic           result_stall,
    output ctac_pkg::cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_HOURS = 9'b000000010,
        S_MINS  = 9'b000000100,
        S_SECS  = 9'b000001000,
        S_TICK  = 9'b000010000,
        S_DIVB  = 9'b000100000,
        S_REMB  = 9'b001000000,
        S_DIV24 = 9'b010000000,
        S_FIN   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   result_valid_reg, result_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free      = !result_valid_reg || !result_stall;
    assign request_stall = !((state_reg == S_IDLE) || (state_reg == S_FIN && out_free));
    assign accept        = request_valid && !request_stall;

    always_comb
    begin
        cmd        = '0;
        cmd.load   = accept;
        cmd.hours  = state_reg == S_HOURS;
        cmd.mins   = state_reg == S_MINS;
        cmd.secs   = state_reg == S_SECS;
        cmd.tick   = state_reg == S_TICK;
        cmd.divb   = state_reg == S_DIVB;
        cmd.remb   = state_reg == S_REMB;
        cmd.div24  = state_reg == S_DIV24;
        cmd.finish = (state_reg == S_FIN) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_HOURS;
            S_HOURS: state_next = S_MINS;
            S_MINS:  state_next = S_SECS;
            S_SECS:  state_next = S_TICK;
            S_TICK:  state_next = S_DIVB;
            S_DIVB:  state_next = S_REMB;
            S_REMB:  state_next = S_DIV24;
            S_DIV24: state_next = S_FIN;
            S_FIN:
            begin
                // a new request may enter as this result leaves
                if (accept)
                    state_next = S_HOURS;
                else if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        result_valid_next = cmd.finish || (result_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

`ifndef SYNTH
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##8 (state_reg == S_FIN))
        else $error("request did not reach the finish step after eight cycles");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> result_valid_reg)
        else $error("finished result not presented");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result valid raised outside the finish step");
`endif

endmodule

// File: rtl/calendar_tick_alarm_calculator.sv
`timescale 1ns / 1ps
// channel   payload      handshake                   accepted when
// request   request_t    request_valid/request_stall valid & !stall
// result    result_t     result_valid/result_stall   valid & !stall
// config    APB          psel/penable/pwrite/pready  access phase, pready tied high
//
// A request steps through the hours, mins, secs, tick, divb, remb, div24 and
// finish states; a new one is taken only from idle or the finish step. The
// steps form a chain of constant multiplies (calendar to seconds, 2.048 s
// scaling, two divides by 60 and one by 24).
// rst_n clears the sequencer, result valid, the alarm context and the configuration registers.
// A stalled result holds the finish step and the request side with it; from
// idle one request may still enter behind it.

module calendar_tick_alarm_calculator
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               request_valid,
    output logic               request_stall,
    input  ctac_pkg::request_t request,
    output logic               result_valid,
    input  logic               result_stall,
    output ctac_pkg::result_t  result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    ctac_pkg::cmd_t cmd;
    logic [7:0]     wake_up_time;
    logic [5:0]     timeout_floor;

    ctac_regs u_regs
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .wake_up_time  (wake_up_time),
        .timeout_floor (timeout_floor)
    );

    ctac_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .cmd           (cmd)
    );

    ctac_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .request       (request),
        .wake_up_time  (wake_up_time),
        .timeout_floor (timeout_floor),
        .result        (result)
    );

endmodule
